// ----- design/fbpe_pkg.sv -----
// types, constants and lookup tables for the e-paper frame store pixel engine
// no dependencies; imported by the address stage, the top module and the testbench
`default_nettype none

package fbpe_pkg;

   // panel geometry
   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 384;
   localparam int COLS          = (SCREEN_WIDTH + 3) / 4;
   localparam int STORE_SIZE    = COLS * SCREEN_HEIGHT;
   localparam int ADDR_W        = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

   // coordinate widths: signed rotated coordinates and unsigned checked ones
   localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT)
                            ? ((SCREEN_WIDTH > 1024) ? SCREEN_WIDTH : 1024)
                            : ((SCREEN_HEIGHT > 1024) ? SCREEN_HEIGHT : 1024);
   localparam int COORD_W = $clog2(MAX_DIM) + 2;
   localparam int UC_W    = COORD_W - 1;
   localparam int COL_W   = UC_W - 2;

   // reciprocal constants for the remainder by three
   localparam int MOD3_SHIFT = UC_W + 1;
   localparam int MOD3_MUL   = (2 ** MOD3_SHIFT + 2) / 3;

   // remainders by three of the last physical column and row
   localparam logic [1:0] WM1_MOD3 = 2'((SCREEN_WIDTH - 1) % 3);
   localparam logic [1:0] HM1_MOD3 = 2'((SCREEN_HEIGHT - 1) % 3);

   // request opcodes
   localparam logic OP_DRAW    = 1'b0;
   localparam logic OP_READOUT = 1'b1;

   // color classes of a draw request
   localparam logic [1:0] CLS_WHITE  = 2'd0;
   localparam logic [1:0] CLS_BLACK  = 2'd1;
   localparam logic [1:0] CLS_RED    = 2'd2;
   localparam logic [1:0] CLS_DITHER = 2'd3;

   // stored pixel codes
   localparam logic [1:0] CODE_BLACK = 2'd0;
   localparam logic [1:0] CODE_RED   = 2'd1;
   localparam logic [1:0] CODE_WHITE = 2'd3;

   // panel code for red
   localparam logic [3:0] PANEL_RED = 4'd4;

   // orientation codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // dither threshold level from (y%3)*3 + x%3
   localparam logic [3:0] DITHER_MATRIX [9] = '{
      4'd0, 4'd7, 4'd3, 4'd6, 4'd5, 4'd2, 4'd4, 4'd1, 4'd8};

   // luma offset trunc(128*(m/9-0.5)) indexed by level m
   localparam logic signed [7:0] DITHER_OFFSET [9] = '{
      -8'sd64, -8'sd49, -8'sd35, -8'sd21, -8'sd7, 8'sd7, 8'sd21, 8'sd35, 8'sd49};

   // bits kept in a byte when one pixel lane is rewritten
   localparam logic [7:0] KEEP_MASK [4] = '{8'd252, 8'd243, 8'd207, 8'd63};

   // one request
   typedef struct packed {
      logic       opcode;
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
      logic [1:0] color_class;
      logic [7:0] luma;
      logic [8:0] read_row;
      logic [7:0] read_col;
   } req_type;

   // one result
   typedef struct packed {
      logic [7:0] panel_byte;
      logic       last;
   } rsp_type;

   // address stage result handed to the sequencer
   typedef struct packed {
      logic              opcode;
      logic              in_range;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        lane;
      logic [1:0]        code;
   } calc_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROTATE,
      ST_CALC,
      ST_READ,
      ST_MODIFY,
      ST_OUT0,
      ST_OUT1
   } state_type;

   // remainder by three through a reciprocal multiply and one correction
   function automatic logic [1:0] mod3(input logic [UC_W-1:0] v);
      logic [2*UC_W:0]  prod;
      logic [UC_W-1:0]  q;
      logic [UC_W+1:0]  r;
      prod = (2*UC_W+1)'(v) * (2*UC_W+1)'(MOD3_MUL);
      q    = UC_W'(prod >> MOD3_SHIFT);
      r    = (UC_W+2)'(v) - ((UC_W+2)'(q) << 1) - (UC_W+2)'(q);
      if (r >= (UC_W+2)'(3)) begin
         r = r - (UC_W+2)'(3);
      end
      return r[1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/fbpe_ram.sv -----
// generic single-clock ram with one write port and one registered read port
// no dependencies
`default_nettype none

module fbpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire                                             clock,
   input  wire                                             wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  wire  [WIDTH-1:0]                                wr_data,
   input  wire                                             rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/fbpe_addr_calc.sv -----
// address stage: rotation, range check, dither decision and byte address
// in two register stages; depends on fbpe_pkg
`default_nettype none

module fbpe_addr_calc (
   input  wire                 clock,
   input  wire                 rot_load,
   input  wire                 load,
   input  wire  [1:0]          orientation,
   input  fbpe_pkg::req_type   req,
   output fbpe_pkg::calc_type  calc_out
);

   import fbpe_pkg::*;

   localparam logic signed [COORD_W-1:0] W_S = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] H_S = COORD_W'(SCREEN_HEIGHT);
   localparam logic signed [COORD_W-1:0] ONE_S = COORD_W'(1);

   logic signed [COORD_W-1:0] px;
   logic signed [COORD_W-1:0] py;
   logic signed [COORD_W-1:0] rx;
   logic signed [COORD_W-1:0] ry;
   logic [1:0]                px3;
   logic [1:0]                py3;
   logic                      draw_ok_in;
   logic                      draw_ok_ff;
   logic [UC_W-1:0]           ux_in;
   logic [UC_W-1:0]           ux_ff;
   logic [UC_W-1:0]           uy_in;
   logic [UC_W-1:0]           uy_ff;
   logic [1:0]                x3_in;
   logic [1:0]                x3_ff;
   logic [1:0]                y3_in;
   logic [1:0]                y3_ff;
   logic                      read_ok;
   logic [3:0]                level_idx;
   logic signed [9:0]         dither_v;
   logic [1:0]                code;
   logic [COL_W-1:0]          col_sel;
   logic [UC_W-1:0]           row_sel;
   calc_type                  calc_in;
   calc_type                  calc_ff;

   // (c - r) mod 3 for two remainders by three
   function automatic logic [1:0] sub_mod3(input logic [1:0] c, input logic [1:0] r);
      return (c >= r) ? (c - r) : (c + 2'd3 - r);
   endfunction

   // rotate logical coordinates onto the physical panel, remainders follow along
   always_comb begin
      px  = $signed(COORD_W'(req.pixel_x));
      py  = $signed(COORD_W'(req.pixel_y));
      px3 = mod3(UC_W'(req.pixel_x));
      py3 = mod3(UC_W'(req.pixel_y));
      unique case (orientation)
         ROT_0: begin
            rx    = px;
            ry    = py;
            x3_in = px3;
            y3_in = py3;
         end
         ROT_90: begin
            rx    = py;
            ry    = H_S - ONE_S - px;
            x3_in = py3;
            y3_in = sub_mod3(HM1_MOD3, px3);
         end
         ROT_180: begin
            rx    = W_S - ONE_S - px;
            ry    = H_S - ONE_S - py;
            x3_in = sub_mod3(WM1_MOD3, px3);
            y3_in = sub_mod3(HM1_MOD3, py3);
         end
         default: begin
            rx    = W_S - ONE_S - py;
            ry    = px;
            x3_in = sub_mod3(WM1_MOD3, py3);
            y3_in = px3;
         end
      endcase
   end

   // draw range check
   assign draw_ok_in = !rx[COORD_W-1] && (rx < W_S) && !ry[COORD_W-1] && (ry < H_S);

   assign ux_in = rx[UC_W-1:0];
   assign uy_in = ry[UC_W-1:0];

   // rotation stage register
   always_ff @(posedge clock) begin
      if (rot_load) begin
         ux_ff      <= ux_in;
         uy_ff      <= uy_in;
         draw_ok_ff <= draw_ok_in;
         x3_ff      <= x3_in;
         y3_ff      <= y3_in;
      end
   end

   // readout range check
   assign read_ok = (UC_W'(req.read_row) < UC_W'(SCREEN_HEIGHT))
                 && (UC_W'(req.read_col) < UC_W'(COLS));

   // ordered dither against the 3x3 threshold matrix
   always_comb begin
      level_idx = (4'(y3_ff) << 1) + 4'(y3_ff) + 4'(x3_ff);
      dither_v  = $signed({2'b00, req.luma})
                + 10'(DITHER_OFFSET[DITHER_MATRIX[level_idx]]);
   end

   // pixel code for the color class
   always_comb begin
      unique case (req.color_class)
         CLS_WHITE: code = CODE_WHITE;
         CLS_BLACK: code = CODE_BLACK;
         CLS_RED:   code = CODE_RED;
         default:   code = (dither_v < 10'sd128) ? CODE_BLACK : CODE_WHITE;
      endcase
   end

   // byte address, one multiplier shared by draw and readout
   always_comb begin
      if (req.opcode == OP_READOUT) begin
         col_sel = COL_W'(req.read_col);
         row_sel = UC_W'(req.read_row);
      end else begin
         col_sel = ux_ff[UC_W-1:2];
         row_sel = uy_ff;
      end
      calc_in.opcode   = req.opcode;
      calc_in.in_range = (req.opcode == OP_READOUT) ? read_ok : draw_ok_ff;
      calc_in.addr     = ADDR_W'(ADDR_W'(SCREEN_HEIGHT) * ADDR_W'(col_sel))
                       + ADDR_W'(row_sel);
      calc_in.lane     = ux_ff[1:0];
      calc_in.code     = code;
   end

   // stage register
   always_ff @(posedge clock) begin
      if (load) begin
         calc_ff <= calc_in;
      end
   end

   assign calc_out = calc_ff;

endmodule

`default_nettype wire

// ----- design/epaper_framebuffer_pixel_engine.sv -----
// Frame store and pixel engine for a three-color e-paper panel.
// Draw request: after acceptance it passes the rotate, address and read states and the byte is
// rewritten in place in the modify state; a draw off the panel returns to idle after read.
// Readout request: after rotate, address and read, results are on the ports in ST_OUT0 and
// ST_OUT1; the next request is accepted once back in idle. Results cannot be stalled.
// After reset the store is cleared one byte a cycle (STORE_SIZE = 61440 bytes), busy high.
`default_nettype none

module epaper_framebuffer_pixel_engine (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  fbpe_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output fbpe_pkg::rsp_type  rsp_data,
   input  wire                csr_we,
   input  wire  [1:0]         csr_wdata
);

   import fbpe_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

   state_type          state_ff;
   state_type          state_in;
   logic [ADDR_W-1:0]  clr_ff;
   logic [ADDR_W-1:0]  clr_in;
   logic [1:0]         orientation_ff;
   req_type            req_ff;
   calc_type           calc;
   logic               accept;
   logic               rot_load;
   logic               calc_load;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [7:0]         ram_wdata;
   logic               ram_re;
   logic [7:0]         ram_rdata;
   logic [7:0]         merged;
   logic [7:0]         stored;

   // stored code to panel nibble
   function automatic logic [3:0] panel_code(input logic [1:0] c);
      return (c == CODE_RED) ? PANEL_RED : 4'(c);
   endfunction

   assign accept = start && !busy;

   // orientation register
   always_ff @(posedge clock) begin
      if (reset) begin
         orientation_ff <= ROT_0;
      end else if (csr_we) begin
         orientation_ff <= csr_wdata;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // address stage
   fbpe_addr_calc u_addr_calc (
      .clock       (clock),
      .rot_load    (rot_load),
      .load        (calc_load),
      .orientation (orientation_ff),
      .req         (req_ff),
      .calc_out    (calc)
   );

   // frame store
   fbpe_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (calc.addr),
      .rd_data (ram_rdata)
   );

   // read-modify-write merge of one pixel lane
   assign merged = (ram_rdata & KEEP_MASK[calc.lane])
                 | (8'(calc.code) << {calc.lane, 1'b0});

   // readout byte, zero outside the store
   assign stored = calc.in_range ? ram_rdata : 8'd0;

   // state and clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // sequencer
   always_comb begin
      state_in            = state_ff;
      clr_in              = clr_ff;
      busy                = 1'b1;
      rot_load            = 1'b0;
      calc_load           = 1'b0;
      ram_we              = 1'b0;
      ram_waddr           = calc.addr;
      ram_wdata           = merged;
      ram_re              = 1'b0;
      rsp_strobe          = 1'b0;
      rsp_data.panel_byte = {panel_code(stored[1:0]), panel_code(stored[3:2])};
      rsp_data.last       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'd0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            rot_load = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            calc_load = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            ram_re = calc.in_range;
            if (calc.opcode == OP_READOUT) begin
               state_in = ST_OUT0;
            end else if (calc.in_range) begin
               state_in = ST_MODIFY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MODIFY: begin
            ram_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_OUT0: begin
            rsp_strobe = 1'b1;
            state_in   = ST_OUT1;
         end
         ST_OUT1: begin
            rsp_strobe          = 1'b1;
            rsp_data.panel_byte = {panel_code(stored[5:4]), panel_code(stored[7:6])};
            rsp_data.last       = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a readout emits its first byte then its last byte
   a_first_then_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe && rsp_data.last)
      else $error("readout first byte not followed by last byte");

   a_last_after_first: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |-> $past(rsp_strobe) && !$past(rsp_data.last))
      else $error("last byte without preceding first byte");

   // an accepted request keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a request");

   // the clearing pass holds off requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> busy && !rsp_strobe)
      else $error("block idle before frame store clear");

   // no store write while a result is on the ports
   a_no_write_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !ram_we && busy)
      else $error("store write during readout");

endmodule

`default_nettype wire

// ----- sim/tb_epaper_framebuffer_pixel_engine.sv -----
// self-checking testbench for the e-paper frame store pixel engine: draw and readout
// requests under every orientation, checked against a shadow copy of the store
// depends on design/fbpe_pkg.sv and design/epaper_framebuffer_pixel_engine.sv
`default_nettype none

module tb_epaper_framebuffer_pixel_engine;
   import fbpe_pkg::*;

   localparam int STALL_LIMIT  = 200000;
   localparam int BLOCK_ITEMS  = 145;
   localparam int NUM_BLOCKS   = 12;
   localparam int SETTLE_TICKS = 8;
   localparam int TOUCHED_MAX  = 64;

   // threshold level by (y%3)*3 + x%3
   localparam int DITHER_LEVELS [9] = '{0, 7, 3, 6, 5, 2, 4, 1, 8};
   // coordinate values on and around the panel edges
   localparam int COORD_EDGES [6] = '{0, 383, 384, 639, 640, 1023};
   localparam int ROW_EDGES [4] = '{0, 383, 384, 511};
   localparam int COL_EDGES [4] = '{0, 159, 160, 255};
   // orientation for each random block
   localparam logic [1:0] BLOCK_ROT [NUM_BLOCKS] = '{
      ROT_0, ROT_270, ROT_90, ROT_180, ROT_270, ROT_0,
      ROT_180, ROT_90, ROT_90, ROT_180, ROT_270, ROT_0};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_wdata = 2'd0;

   // shadow state of the block
   logic [7:0] shadow_store [STORE_SIZE];
   logic [1:0] rot_setting = ROT_0;

   req_type pending_requests [$];
   rsp_type panel_bytes_due [$];
   int      touched_bytes [$];
   int      sender_idle_pct = 9;
   int      win_x = 0;
   int      win_y = 0;
   int      mismatches = 0;
   int      stall_cycles = 0;
   rsp_type want_rsp;

   epaper_framebuffer_pixel_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ordered dither of one physical pixel
   function automatic logic [1:0] dither_pixel(int x, int y, logic [7:0] luma);
      int level;
      int offset;
      int v;
      level  = DITHER_LEVELS[(y % 3) * 3 + (x % 3)];
      offset = (128 * level - 576) / 9;
      v      = int'(luma) + offset;
      return (v < 128) ? CODE_BLACK : CODE_WHITE;
   endfunction

   // stored code to panel nibble, red moves to its own code
   function automatic logic [3:0] to_panel(logic [1:0] c);
      return (c == CODE_RED) ? PANEL_RED : {2'b00, c};
   endfunction

   // rotate, range check and rewrite one pixel lane of the shadow store
   task automatic paint_shadow_pixel(input req_type r);
      int px;
      int py;
      int x;
      int y;
      int addr;
      int lane;
      logic [1:0] code;
      px = int'(r.pixel_x);
      py = int'(r.pixel_y);
      case (rot_setting)
         ROT_90: begin
            x = py;
            y = SCREEN_HEIGHT - 1 - px;
         end
         ROT_180: begin
            x = SCREEN_WIDTH - 1 - px;
            y = SCREEN_HEIGHT - 1 - py;
         end
         ROT_270: begin
            x = SCREEN_WIDTH - 1 - py;
            y = px;
         end
         default: begin
            x = px;
            y = py;
         end
      endcase
      if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) begin
         return;
      end
      case (r.color_class)
         CLS_WHITE: code = CODE_WHITE;
         CLS_BLACK: code = CODE_BLACK;
         CLS_RED:   code = CODE_RED;
         default:   code = dither_pixel(x, y, r.luma);
      endcase
      addr = SCREEN_HEIGHT * (x / 4) + y;
      lane = x % 4;
      shadow_store[addr][2*lane +: 2] = code;
      touched_bytes.push_back(addr);
      if (touched_bytes.size() > TOUCHED_MAX) begin
         void'(touched_bytes.pop_front());
      end
   endtask

   // two panel bytes of one stored byte, zero outside the store
   task automatic queue_readout_bytes(input req_type r);
      logic [7:0] b;
      rsp_type    res;
      b = 8'd0;
      if (int'(r.read_row) < SCREEN_HEIGHT && int'(r.read_col) < COLS) begin
         b = shadow_store[SCREEN_HEIGHT * int'(r.read_col) + int'(r.read_row)];
      end
      res.panel_byte = {to_panel(b[1:0]), to_panel(b[3:2])};
      res.last       = 1'b0;
      panel_bytes_due.push_back(res);
      res.panel_byte = {to_panel(b[5:4]), to_panel(b[7:6])};
      res.last       = 1'b1;
      panel_bytes_due.push_back(res);
   endtask

   function automatic req_type compose_request(logic op, int x, int y, logic [1:0] cls,
                                               int luma, int row, int col);
      req_type r;
      r.opcode      = op;
      r.pixel_x     = 10'(x);
      r.pixel_y     = 10'(y);
      r.color_class = cls;
      r.luma        = 8'(luma);
      r.read_row    = 9'(row);
      r.read_col    = 8'(col);
      return r;
   endfunction

   // mostly a small window so bytes fill up lane by lane, some edges and noise
   function automatic logic [9:0] pick_coord(int base);
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) begin
         return 10'(base + $urandom_range(7));
      end else if (roll < 80) begin
         return 10'($urandom_range(639));
      end else if (roll < 90) begin
         return 10'(COORD_EDGES[$urandom_range(5)]);
      end
      return 10'($urandom_range(1023));
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      addr;
      int      roll;
      r.opcode      = ($urandom_range(99) < 58) ? OP_DRAW : OP_READOUT;
      r.pixel_x     = pick_coord(win_x);
      r.pixel_y     = pick_coord(win_y);
      r.color_class = 2'($urandom_range(3));
      r.luma        = ($urandom_range(3) == 0) ? 8'(120 + $urandom_range(16))
                                               : 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 65 && touched_bytes.size() != 0) begin
         addr       = touched_bytes[$urandom_range(touched_bytes.size() - 1)];
         r.read_row = 9'(addr % SCREEN_HEIGHT);
         r.read_col = 8'(addr / SCREEN_HEIGHT);
      end else if (roll < 80) begin
         r.read_row = 9'(ROW_EDGES[$urandom_range(3)]);
         r.read_col = 8'(COL_EDGES[$urandom_range(3)]);
      end else begin
         r.read_row = 9'($urandom_range(511));
         r.read_col = 8'($urandom_range(255));
      end
      return r;
   endfunction

   // keep a few requests ahead of the driver
   task automatic queue_request(input req_type r);
      while (pending_requests.size() >= 4) begin
         @(posedge clock);
      end
      pending_requests.push_back(r);
   endtask

   // all requests accepted, all results in, last write back done
   task automatic wait_block_idle();
      while (pending_requests.size() != 0 || panel_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_orientation(input logic [1:0] rot);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= rot;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // request driver and shadow update at acceptance
   always @(posedge clock) begin
      if (csr_we) begin
         rot_setting = csr_wdata;
      end
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (req_data.opcode == OP_DRAW) begin
               paint_shadow_pixel(req_data);
            end else begin
               queue_readout_bytes(req_data);
            end
            void'(pending_requests.pop_front());
         end
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_requests[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (panel_bytes_due.size() == 0) begin
            $error("unexpected result: panel_byte %0h last %0b",
                   rsp_data.panel_byte, rsp_data.last);
            mismatches++;
         end else begin
            want_rsp = panel_bytes_due.pop_front();
            if (rsp_data.panel_byte !== want_rsp.panel_byte) begin
               $error("panel_byte: expected %0h, actual %0h",
                      want_rsp.panel_byte, rsp_data.panel_byte);
               mismatches++;
            end
            if (rsp_data.last !== want_rsp.last) begin
               $error("last: expected %0b, actual %0b", want_rsp.last, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no traffic, the clearing pass included
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || csr_we) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < STORE_SIZE; i++) begin
         shadow_store[i] = 8'd0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every class, dither extremes, corners, off-panel draws and reads
      sender_idle_pct = 9;
      queue_request(compose_request(OP_DRAW, 0, 0, CLS_WHITE, 0, 0, 0));
      queue_request(compose_request(OP_DRAW, 1, 0, CLS_BLACK, 255, 511, 255));
      queue_request(compose_request(OP_DRAW, 2, 0, CLS_RED, 0, 0, 0));
      queue_request(compose_request(OP_DRAW, 3, 0, CLS_DITHER, 128, 0, 0));
      queue_request(compose_request(OP_READOUT, 1023, 1023, CLS_DITHER, 255, 0, 0));
      queue_request(compose_request(OP_DRAW, 0, 1, CLS_DITHER, 255, 0, 0));
      queue_request(compose_request(OP_DRAW, 1, 1, CLS_DITHER, 0, 0, 0));
      queue_request(compose_request(OP_DRAW, 2, 1, CLS_RED, 0, 0, 0));
      queue_request(compose_request(OP_DRAW, 3, 1, CLS_WHITE, 0, 0, 0));
      queue_request(compose_request(OP_READOUT, 0, 0, CLS_WHITE, 0, 1, 0));
      queue_request(compose_request(OP_DRAW, 639, 383, CLS_WHITE, 0, 0, 0));
      queue_request(compose_request(OP_DRAW, 636, 383, CLS_RED, 0, 0, 0));
      queue_request(compose_request(OP_READOUT, 0, 0, CLS_WHITE, 0, 383, 159));
      queue_request(compose_request(OP_DRAW, 640, 0, CLS_RED, 0, 0, 0));
      queue_request(compose_request(OP_DRAW, 0, 384, CLS_RED, 0, 0, 0));
      queue_request(compose_request(OP_DRAW, 1023, 1023, CLS_DITHER, 255, 511, 255));
      queue_request(compose_request(OP_READOUT, 0, 0, CLS_WHITE, 0, 0, 160));
      queue_request(compose_request(OP_READOUT, 0, 0, CLS_WHITE, 0, 384, 0));
      queue_request(compose_request(OP_READOUT, 1023, 1023, CLS_DITHER, 255, 511, 255));
      queue_request(compose_request(OP_DRAW, 5, 4, CLS_DITHER, 127, 0, 0));
      queue_request(compose_request(OP_DRAW, 4, 5, CLS_DITHER, 135, 0, 0));
      queue_request(compose_request(OP_DRAW, 6, 5, CLS_DITHER, 121, 0, 0));
      queue_request(compose_request(OP_READOUT, 0, 0, CLS_WHITE, 0, 4, 1));
      queue_request(compose_request(OP_READOUT, 0, 0, CLS_WHITE, 0, 5, 1));

      // random blocks, orientation changed only while idle
      for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
         wait_block_idle();
         write_orientation(BLOCK_ROT[blk]);
         sender_idle_pct = (blk < 4) ? 9 : ((blk < 8) ? 58 : 0);
         win_x = $urandom_range(632);
         win_y = $urandom_range(632);
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            if (n % 40 == 39) begin
               win_x = $urandom_range(632);
               win_y = $urandom_range(632);
            end
            queue_request(random_request());
         end
      end

      wait_block_idle();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
design/fbpe_pkg.sv
design/fbpe_ram.sv
design/fbpe_addr_calc.sv
design/epaper_framebuffer_pixel_engine.sv
sim/tb_epaper_framebuffer_pixel_engine.sv
